/* rtl/gpnf_pkg.sv */
// gaze point noise filter: shared widths, register codes and configuration type
// no dependencies; used by every module of the filter
`timescale 1ns / 1ps

package gpnf_pkg;

	localparam int unsigned COORD_W   = 24;
	localparam int unsigned ERR_W     = 25;
	localparam int unsigned ACC_W     = 32;
	localparam int unsigned LIMIT_W   = 48;
	localparam int unsigned ZONE_W    = 23;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JUMP_LIMIT_SQ = 3'd0,
		REG_DEAD_ZONE     = 3'd1,
		REG_SLOW_ZONE     = 3'd2,
		REG_FAST_GAIN     = 3'd3,
		REG_SLOW_GAIN     = 3'd4,
		REG_INTEG_LIMIT   = 3'd5,
		REG_INTEG_GAIN    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] jump_limit_sq;
		logic [ZONE_W-1:0]  dead_zone;
		logic [ZONE_W-1:0]  slow_zone;
		logic [GAIN_W-1:0]  fast_gain;
		logic [GAIN_W-1:0]  slow_gain;
		logic [ZONE_W-1:0]  integ_limit;
		logic [GAIN_W-1:0]  integ_gain;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		jump_limit_sq: 48'd20971520,
		dead_zone:     23'd2048,
		slow_zone:     23'd10240,
		fast_gain:     16'd32768,
		slow_gain:     16'd2621,
		integ_limit:   23'd256,
		integ_gain:    16'd13107
	};

endpackage

/* rtl/gpnf_cfg_regs.sv */
// gaze point noise filter: configuration register file with its write channel
// depends on gpnf_pkg
`timescale 1ns / 1ps

module gpnf_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gpnf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpnf_pkg::LIMIT_W-1:0]       cfg_data,
	output gpnf_pkg::cfg_t                     cfg
);

	gpnf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gpnf_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (gpnf_pkg::cfg_reg_t'(cfg_index))
				gpnf_pkg::REG_JUMP_LIMIT_SQ: cfg_q.jump_limit_sq <= cfg_data;
				gpnf_pkg::REG_DEAD_ZONE:     cfg_q.dead_zone   <= cfg_data[gpnf_pkg::ZONE_W-1:0];
				gpnf_pkg::REG_SLOW_ZONE:     cfg_q.slow_zone   <= cfg_data[gpnf_pkg::ZONE_W-1:0];
				gpnf_pkg::REG_FAST_GAIN:     cfg_q.fast_gain   <= cfg_data[gpnf_pkg::GAIN_W-1:0];
				gpnf_pkg::REG_SLOW_GAIN:     cfg_q.slow_gain   <= cfg_data[gpnf_pkg::GAIN_W-1:0];
				gpnf_pkg::REG_INTEG_LIMIT:   cfg_q.integ_limit <= cfg_data[gpnf_pkg::ZONE_W-1:0];
				gpnf_pkg::REG_INTEG_GAIN:    cfg_q.integ_gain  <= cfg_data[gpnf_pkg::GAIN_W-1:0];
				default: begin
					// unused index, transaction dropped
				end
			endcase
		end
	end

endmodule

/* rtl/gpnf_jump_test.sv */
// gaze point noise filter: squared distance from reference point and jump decision
// depends on gpnf_pkg
`timescale 1ns / 1ps

module gpnf_jump_test (
	input  gpnf_pkg::coord_t             ref_x,
	input  gpnf_pkg::coord_t             ref_y,
	input  gpnf_pkg::coord_t             raw_x,
	input  gpnf_pkg::coord_t             raw_y,
	input  logic [gpnf_pkg::LIMIT_W-1:0] jump_limit_sq,
	output logic                         reject
);

	gpnf_pkg::err_t     dx;
	gpnf_pkg::err_t     dy;
	logic signed [49:0] dx_sq;
	logic signed [49:0] dy_sq;
	logic [49:0]        dist_sq;

	assign dx      = 25'(ref_x) - 25'(raw_x);
	assign dy      = 25'(ref_y) - 25'(raw_y);
	assign dx_sq   = dx * dx;
	assign dy_sq   = dy * dy;
	assign dist_sq = $unsigned(dx_sq) + $unsigned(dy_sq);
	assign reject  = dist_sq > {2'b00, jump_limit_sq};

endmodule

/* rtl/gpnf_axis_update.sv */
// gaze point noise filter: one axis of the proportional and integral update
// depends on gpnf_pkg
`timescale 1ns / 1ps

module gpnf_axis_update (
	input  gpnf_pkg::coord_t            filt,
	input  gpnf_pkg::acc_t              acc,
	input  gpnf_pkg::err_t              err,
	input  logic [gpnf_pkg::GAIN_W-1:0] gain,
	input  logic [gpnf_pkg::ZONE_W-1:0] dead_zone,
	input  logic [gpnf_pkg::ZONE_W-1:0] integ_limit,
	input  logic [gpnf_pkg::GAIN_W-1:0] integ_gain,
	output gpnf_pkg::coord_t            filt_next,
	output gpnf_pkg::acc_t              acc_next
);

	logic signed [32:0] acc_sum;
	gpnf_pkg::acc_t     acc_sat;
	logic [24:0]        err_mag;
	logic [32:0]        acc_mag;
	logic signed [41:0] p_prod;
	logic signed [42:0] p_rnd;
	logic signed [26:0] p_move;
	logic signed [48:0] i_prod;
	logic signed [49:0] i_rnd;
	logic signed [33:0] i_move;
	logic               p_on;
	logic               fire;
	logic signed [34:0] move;
	logic signed [35:0] filt_sum;

	assign acc_sum = 33'(acc) + 33'(err);

	// clamp to 32 bits when the top two bits disagree
	always_comb begin
		if (acc_sum[32] != acc_sum[31]) begin
			acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			acc_sat = $signed(acc_sum[31:0]);
		end
	end

	assign err_mag = err[24] ? 25'($unsigned(-err)) : 25'($unsigned(err));
	assign acc_mag = acc_sat[31] ? $unsigned(-33'(acc_sat)) : $unsigned(33'(acc_sat));

	// gain times value, round half up back to Q16.8
	assign p_prod = $signed({1'b0, gain}) * err;
	assign p_rnd  = 43'(p_prod) + 43'sd32768;
	assign p_move = $signed(p_rnd[42:16]);

	assign i_prod = $signed({1'b0, integ_gain}) * acc_sat;
	assign i_rnd  = 50'(i_prod) + 50'sd32768;
	assign i_move = $signed(i_rnd[49:16]);

	assign p_on = err_mag > 25'(dead_zone);
	assign fire = acc_mag > 33'(integ_limit);

	assign move     = (p_on ? 35'(p_move) : 35'sd0) + (fire ? 35'(i_move) : 35'sd0);
	assign filt_sum = 36'(filt) + 36'(move);

	always_comb begin
		if (filt_sum > 36'sd8388607) begin
			filt_next = 24'sh7f_ffff;
		end else if (filt_sum < -36'sd8388608) begin
			filt_next = 24'sh80_0000;
		end else begin
			filt_next = $signed(filt_sum[23:0]);
		end
	end

	assign acc_next = fire ? '0 : acc_sat;

endmodule

/* rtl/gaze_point_noise_filter_core.sv */
// gaze point noise filter: top level with input register, state and result register
// depends on gpnf_pkg, gpnf_cfg_regs, gpnf_jump_test, gpnf_axis_update
`timescale 1ns / 1ps

// Usage
// Input channel in_valid/in_ready carries one raw gaze point (raw_x, raw_y),
// signed Q16.8 pixels. Output channel out_valid/out_ready returns one filtered
// point (smooth_x, smooth_y) and the rejected flag for each input transaction,
// in order. The configuration channel cfg_valid/cfg_ready writes register
// cfg_index with cfg_data; it is always ready and must only be used while the
// filter holds no item in flight.
// A point is captured in the input register on acceptance; its result is
// written to the result register once that register is empty or being taken.
// Throughput: one point per cycle while not stalled; the jump test and both
// axis updates are combinational from the input register to the filter state.
// Reset: state (reference point, filtered point, accumulators) clears to zero,
// registers take their default values and both channels go empty.
// Stall: while out_ready is low the result holds; the input register still
// takes one more point, after which in_ready drops until the result is taken.

module gaze_point_noise_filter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gpnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpnf_pkg::LIMIT_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gpnf_pkg::coord_t               raw_x,
	input  gpnf_pkg::coord_t               raw_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gpnf_pkg::coord_t               smooth_x,
	output gpnf_pkg::coord_t               smooth_y,
	output logic                           rejected
);

	gpnf_pkg::cfg_t   cfg;

	logic             valid_s1;
	gpnf_pkg::coord_t raw_x_s1;
	gpnf_pkg::coord_t raw_y_s1;

	gpnf_pkg::coord_t ref_x_q;
	gpnf_pkg::coord_t ref_y_q;
	gpnf_pkg::coord_t filt_x_q;
	gpnf_pkg::coord_t filt_y_q;
	gpnf_pkg::acc_t   acc_x_q;
	gpnf_pkg::acc_t   acc_y_q;

	logic             out_valid_q;
	gpnf_pkg::coord_t smooth_x_q;
	gpnf_pkg::coord_t smooth_y_q;
	logic             rejected_q;

	logic             advance;
	logic             reject;
	gpnf_pkg::err_t   err_x;
	gpnf_pkg::err_t   err_y;
	logic signed [25:0] err_sum;
	logic [25:0]      err_sum_mag;
	logic [gpnf_pkg::GAIN_W-1:0] gain;
	gpnf_pkg::coord_t filt_x_next;
	gpnf_pkg::coord_t filt_y_next;
	gpnf_pkg::acc_t   acc_x_next;
	gpnf_pkg::acc_t   acc_y_next;

	gpnf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	gpnf_jump_test u_jump_test (
		.ref_x         (ref_x_q),
		.ref_y         (ref_y_q),
		.raw_x         (raw_x_s1),
		.raw_y         (raw_y_s1),
		.jump_limit_sq (cfg.jump_limit_sq),
		.reject        (reject)
	);

	assign err_x       = 25'(raw_x_s1) - 25'(filt_x_q);
	assign err_y       = 25'(raw_y_s1) - 25'(filt_y_q);
	assign err_sum     = 26'(err_x) + 26'(err_y);
	assign err_sum_mag = err_sum[25] ? $unsigned(-err_sum) : $unsigned(err_sum);
	assign gain        = (err_sum_mag > 26'(cfg.slow_zone)) ? cfg.fast_gain : cfg.slow_gain;

	gpnf_axis_update u_axis_x (
		.filt        (filt_x_q),
		.acc         (acc_x_q),
		.err         (err_x),
		.gain        (gain),
		.dead_zone   (cfg.dead_zone),
		.integ_limit (cfg.integ_limit),
		.integ_gain  (cfg.integ_gain),
		.filt_next   (filt_x_next),
		.acc_next    (acc_x_next)
	);

	gpnf_axis_update u_axis_y (
		.filt        (filt_y_q),
		.acc         (acc_y_q),
		.err         (err_y),
		.gain        (gain),
		.dead_zone   (cfg.dead_zone),
		.integ_limit (cfg.integ_limit),
		.integ_gain  (cfg.integ_gain),
		.filt_next   (filt_y_next),
		.acc_next    (acc_y_next)
	);

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ref_x_q     <= '0;
			ref_y_q     <= '0;
			filt_x_q    <= '0;
			filt_y_q    <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (reject) begin
					ref_x_q <= raw_x_s1;
					ref_y_q <= raw_y_s1;
				end else begin
					filt_x_q <= filt_x_next;
					filt_y_q <= filt_y_next;
					acc_x_q  <= acc_x_next;
					acc_y_q  <= acc_y_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_x_s1 <= raw_x;
			raw_y_s1 <= raw_y;
		end
		if (advance) begin
			smooth_x_q <= reject ? filt_x_q : filt_x_next;
			smooth_y_q <= reject ? filt_y_q : filt_y_next;
			rejected_q <= reject;
		end
	end

	assign out_valid = out_valid_q;
	assign smooth_x  = smooth_x_q;
	assign smooth_y  = smooth_y_q;
	assign rejected  = rejected_q;

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	// a rejected point leaves filter state alone
	a_reject_holds_filter: assert property (@(posedge clk) disable iff (!arst_n)
		advance && reject |=> filt_x_q == $past(filt_x_q) && filt_y_q == $past(filt_y_q)
			&& acc_x_q == $past(acc_x_q) && acc_y_q == $past(acc_y_q))
		else $error("filter state changed on rejected point");

	// a rejected point becomes the new reference
	a_reject_moves_ref: assert property (@(posedge clk) disable iff (!arst_n)
		advance && reject |=> ref_x_q == $past(raw_x_s1) && ref_y_q == $past(raw_y_s1))
		else $error("reference not taken from rejected point");

	// reference only moves on rejection
	a_ref_kept: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !reject |=> ref_x_q == $past(ref_x_q) && ref_y_q == $past(ref_y_q))
		else $error("reference moved on accepted point");

	// every processed point produces a result with its flag
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && rejected_q == $past(reject))
		else $error("result missing after processed point");

endmodule
